// ===== design/gfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfs_pkg
// Shared widths, codes and helpers of the GPS fix smoothing filter.
// ----------------------------------------------------------------------------
package gfs_pkg;

  localparam int unsigned MaxWindowDef = 16;
  localparam int unsigned PosW = 41;
  localparam int unsigned AltW = 29;
  localparam int unsigned MulAW = 34;
  localparam int unsigned MulBW = 25;
  localparam int unsigned ProdW = MulAW + MulBW;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 24;

  localparam logic [2:0] VerdictEmit  = 3'd0;
  localparam logic [2:0] VerdictInval = 3'd1;
  localparam logic [2:0] VerdictZero  = 3'd2;
  localparam logic [2:0] VerdictPoor  = 3'd3;
  localparam logic [2:0] VerdictClose = 3'd4;

  localparam logic [CfgIdxW-1:0] RegWindowLen = 2'd0;
  localparam logic [CfgIdxW-1:0] RegScale     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMinMove   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegMaxSigma  = 2'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } gfs_div_st_t;

  function automatic logic signed [PosW-1:0] round_sat(logic signed [ProdW-1:0] p);
    logic [ProdW-1:0] mag;
    logic [ProdW-1:0] sum;
    logic [43:0]      q;
    logic signed [PosW-1:0] r;
    mag = p[ProdW-1] ? ProdW'(-p) : ProdW'(p);
    sum = mag + ProdW'(32768);
    q = 44'(sum >> 16);
    if (p[ProdW-1]) begin
      if (q > 44'h100_0000_0000) r = {1'b1, {(PosW-1){1'b0}}};
      else r = PosW'(-q);
    end else begin
      if (q > 44'h0ff_ffff_ffff) r = {1'b0, {(PosW-1){1'b1}}};
      else r = PosW'(q);
    end
    return r;
  endfunction

endpackage

// ===== design/gfs_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gfs_div #(
  parameter int unsigned DW = 46,
  parameter int unsigned FW = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DW-1:0]        num_i,
  input  logic [FW-1:0]        den_i,
  output gfs_pkg::gfs_div_st_t st_o,
  output logic [DW-1:0]        quo_o
);
  import gfs_pkg::*;

  localparam int unsigned CntW = $clog2(DW + 1);

  logic [DW-1:0]   quo_q, quo_d;
  logic [FW-1:0]   rem_q, rem_d;
  logic [FW-1:0]   den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [FW:0]     sh, diff;
  logic            ge;

  assign sh   = {rem_q, quo_q[DW-1]};
  assign diff = sh - {1'b0, den_q};
  assign ge   = sh >= {1'b0, den_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = CntW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[DW-2:0], ge};
      rem_d = ge ? diff[FW-1:0] : sh[FW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign st_o.busy = busy_q;
  assign st_o.done = done_q;
  assign quo_o     = quo_q;

endmodule

// ===== design/gfs_win.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfs_win
// Window point store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module gfs_win #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IW = 4,
  parameter int unsigned DATA_W = 111
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [IW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [IW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);
  import gfs_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/gps_fix_smoothing_filter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_fix_smoothing_filter_top
// Gates GPS fixes, averages them over a moving window and drops small moves.
// ----------------------------------------------------------------------------
// Input words arrive on in_valid_i / in_stall_o, one fix per word; results
// leave on out_valid_o / out_stall_i, one verdict word per fix. Config writes
// use cfg_valid_i / cfg_ready_o (always ready), index 0 window length,
// 1 scale, 2 minimum move, 3 maximum sigma.
// A rejected fix steps through S_CHK, and S_VAR if needed, to S_OUT. An
// accepted fix runs through one shared 34x25 multiplier (sigma square, x
// and y scaling, three distance squares, limit square) and one bit-serial
// divider that runs three passes, one per axis. in_stall_o is high while a
// fix is at work; a finished word waits in the output register, and a new
// fix may enter meanwhile, but the sequencer holds at its last step while
// the receiver stalls. Reset clears the origin, window fill, sums and last
// point and restores the register defaults; the window store needs no
// clearing.
// ----------------------------------------------------------------------------
module gps_fix_smoothing_filter_top #(
  parameter int unsigned MAX_WINDOW = gfs_pkg::MaxWindowDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          fix_valid_i,
  input  logic signed [30:0]            lat_e7_i,
  input  logic signed [31:0]            lon_e7_i,
  input  logic                          alt_present_i,
  input  logic signed [27:0]            alt_mm_i,
  input  logic [39:0]                   h_variance_mm2_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    verdict_o,
  output logic signed [40:0]            pos_x_o,
  output logic signed [40:0]            pos_y_o,
  output logic signed [28:0]            pos_z_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gfs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gfs_pkg::CfgDataW-1:0]  cfg_data_i
);
  import gfs_pkg::*;

  localparam int unsigned IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned FW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned LW = (FW > 5) ? FW : 5;
  localparam int unsigned SUM_W = PosW + FW;
  localparam int unsigned DATA_W = 2 * PosW + AltW;

  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_CHK  = 15'b000000000000010,
    S_VAR  = 15'b000000000000100,
    S_MX   = 15'b000000000001000,
    S_MY   = 15'b000000000010000,
    S_SUB  = 15'b000000000100000,
    S_ADD  = 15'b000000001000000,
    S_DIVS = 15'b000000010000000,
    S_DIVW = 15'b000000100000000,
    S_SQ0  = 15'b000001000000000,
    S_SQ1  = 15'b000010000000000,
    S_SQ2  = 15'b000100000000000,
    S_SQ3  = 15'b001000000000000,
    S_CMP  = 15'b010000000000000,
    S_OUT  = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  logic [4:0]  win_len_q;
  logic [23:0] scale_q;
  logic [19:0] min_move_q, max_sigma_q;

  logic                    fv_q, ap_q;
  logic signed [30:0]      lat_q;
  logic signed [31:0]      lon_q;
  logic signed [27:0]      alt_q;
  logic [39:0]             var_q;

  logic                    org_known_q;
  logic signed [30:0]      org_lat_q;
  logic signed [31:0]      org_lon_q;
  logic signed [27:0]      org_alt_q;

  logic [IW-1:0]           head_q;
  logic [FW-1:0]           fill_q;
  logic signed [SUM_W-1:0] sum_q [3];
  logic                    last_known_q;
  logic signed [PosW-1:0]  last_q [3];
  logic signed [PosW-1:0]  avg_q [3];
  logic signed [PosW-1:0]  px_q, py_q;
  logic                    drop_q;
  logic [1:0]              comp_q;
  logic [2:0]              verdict_q;
  logic [41:0]             acc_q;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] prod_q;

  logic                    out_valid_q;
  logic [2:0]              out_verdict_q;
  logic signed [PosW-1:0]  out_x_q, out_y_q;
  logic signed [AltW-1:0]  out_z_q;

  logic in_acc, out_free;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // window length clamp
  logic [LW-1:0] wl_ext, len_ext;
  logic [FW-1:0] len;
  always_comb begin
    wl_ext = LW'(win_len_q);
    if (wl_ext == '0) len_ext = LW'(1);
    else if (wl_ext > LW'(MAX_WINDOW)) len_ext = LW'(MAX_WINDOW);
    else len_ext = wl_ext;
    len = len_ext[FW-1:0];
  end

  // oldest entry index
  logic [FW:0]   old_t, old_w;
  logic [IW-1:0] old_idx;
  always_comb begin
    old_t = (FW+1)'(head_q) + (FW+1)'(MAX_WINDOW) - (FW+1)'(fill_q);
    old_w = (old_t >= (FW+1)'(MAX_WINDOW)) ? old_t - (FW+1)'(MAX_WINDOW) : old_t;
    old_idx = old_w[IW-1:0];
  end

  logic signed [AltW-1:0] pz;
  assign pz = ap_q ? (AltW'(alt_q) - AltW'(org_alt_q)) : '0;

  logic [DATA_W-1:0] rdata;
  logic              we;
  assign we = (state_q == S_ADD);

  gfs_win #(
    .DEPTH (MAX_WINDOW),
    .IW    (IW),
    .DATA_W(DATA_W)
  ) u_win (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(head_q),
    .wdata_i({pz, py_q, px_q}),
    .raddr_i(old_idx),
    .rdata_o(rdata)
  );

  logic signed [SUM_W-1:0] old_v [3];
  assign old_v[0] = SUM_W'(signed'(rdata[PosW-1:0]));
  assign old_v[1] = SUM_W'(signed'(rdata[2*PosW-1:PosW]));
  assign old_v[2] = SUM_W'(signed'(rdata[DATA_W-1:2*PosW]));

  // divider
  gfs_div_st_t     div_st;
  logic [SUM_W-1:0] div_num, div_quo, sum_mag;
  logic             div_start;
  logic signed [SUM_W-1:0] sum_sel;
  assign sum_sel   = sum_q[comp_q];
  assign sum_mag   = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
  assign div_num   = sum_mag + SUM_W'(fill_q >> 1);
  assign div_start = (state_q == S_DIVS);

  gfs_div #(
    .DW(SUM_W),
    .FW(FW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (fill_q),
    .st_o   (div_st),
    .quo_o  (div_quo)
  );

  logic signed [SUM_W-1:0] quo_signed;
  assign quo_signed = sum_sel[SUM_W-1] ? SUM_W'(-div_quo) : SUM_W'(div_quo);

  // distance to last emitted point
  logic signed [PosW:0] dif [3];
  logic [PosW:0]        dabs [3];
  logic                 far;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dif[k]  = (PosW+1)'(avg_q[k]) - (PosW+1)'(last_q[k]);
      dabs[k] = dif[k][PosW] ? (PosW+1)'(-dif[k]) : (PosW+1)'(dif[k]);
    end
    far = (|dabs[0][PosW:20]) || (|dabs[1][PosW:20]) || (|dabs[2][PosW:20]);
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_CHK: begin
        mul_a = MulAW'(max_sigma_q);
        mul_b = MulBW'(max_sigma_q);
      end
      S_MX: begin
        mul_a = MulAW'(lon_q) - MulAW'(org_lon_q);
        mul_b = MulBW'(scale_q);
      end
      S_MY: begin
        mul_a = MulAW'(lat_q) - MulAW'(org_lat_q);
        mul_b = MulBW'(scale_q);
      end
      S_SQ0: begin
        mul_a = MulAW'(dabs[0][19:0]);
        mul_b = MulBW'(dabs[0][19:0]);
      end
      S_SQ1: begin
        mul_a = MulAW'(dabs[1][19:0]);
        mul_b = MulBW'(dabs[1][19:0]);
      end
      S_SQ2: begin
        mul_a = MulAW'(dabs[2][19:0]);
        mul_b = MulBW'(dabs[2][19:0]);
      end
      S_SQ3: begin
        mul_a = MulAW'(min_move_q);
        mul_b = MulBW'(min_move_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_CHK;
      S_CHK: begin
        if (!fv_q) state_d = S_OUT;
        else if (lat_q > -31'sd10 && lat_q < 31'sd10 && lon_q > -32'sd10 && lon_q < 32'sd10)
          state_d = S_OUT;
        else state_d = S_VAR;
      end
      S_VAR:  state_d = (ProdW'(var_q) > prod_q) ? S_OUT : S_MX;
      S_MX:   state_d = S_MY;
      S_MY:   state_d = S_SUB;
      S_SUB:  state_d = S_ADD;
      S_ADD:  state_d = S_DIVS;
      S_DIVS: state_d = S_DIVW;
      S_DIVW: if (div_st.done) state_d = (comp_q == 2'd2) ? S_SQ0 : S_DIVS;
      S_SQ0:  state_d = S_SQ1;
      S_SQ1:  state_d = S_SQ2;
      S_SQ2:  state_d = S_SQ3;
      S_SQ3:  state_d = S_CMP;
      S_CMP:  state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      win_len_q    <= 5'd5;
      scale_q      <= 24'd655360;
      min_move_q   <= 20'd1000;
      max_sigma_q  <= 20'd5000;
      org_known_q  <= 1'b0;
      org_lat_q    <= '0;
      org_lon_q    <= '0;
      org_alt_q    <= '0;
      head_q       <= '0;
      fill_q       <= '0;
      last_known_q <= 1'b0;
      comp_q       <= '0;
      out_valid_q  <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        sum_q[k]  <= '0;
        last_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegWindowLen: win_len_q   <= cfg_data_i[4:0];
          RegScale:     scale_q     <= cfg_data_i;
          RegMinMove:   min_move_q  <= cfg_data_i[19:0];
          RegMaxSigma:  max_sigma_q <= cfg_data_i[19:0];
          default: ;
        endcase
      end
      if (state_q == S_VAR && !org_known_q && !(ProdW'(var_q) > prod_q)) begin
        org_known_q <= 1'b1;
        org_lat_q   <= lat_q;
        org_lon_q   <= lon_q;
        org_alt_q   <= ap_q ? alt_q : '0;
      end
      if (state_q == S_SUB && drop_q) begin
        for (int k = 0; k < 3; k++) sum_q[k] <= sum_q[k] - old_v[k];
      end
      if (state_q == S_ADD) begin
        sum_q[0] <= sum_q[0] + SUM_W'(px_q);
        sum_q[1] <= sum_q[1] + SUM_W'(py_q);
        sum_q[2] <= sum_q[2] + SUM_W'(pz);
        head_q   <= (head_q == IW'(MAX_WINDOW - 1)) ? '0 : head_q + 1'b1;
        if (!drop_q) fill_q <= fill_q + 1'b1;
        comp_q   <= '0;
      end
      if (state_q == S_DIVW && div_st.done && comp_q != 2'd2) comp_q <= comp_q + 1'b1;
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
        if (verdict_q == VerdictEmit) begin
          last_known_q <= 1'b1;
          for (int k = 0; k < 3; k++) last_q[k] <= avg_q[k];
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fv_q  <= fix_valid_i;
      lat_q <= lat_e7_i;
      lon_q <= lon_e7_i;
      ap_q  <= alt_present_i;
      alt_q <= alt_mm_i;
      var_q <= h_variance_mm2_i;
    end
    unique case (state_q)
      S_CHK: begin
        if (!fv_q) verdict_q <= VerdictInval;
        else verdict_q <= VerdictZero;
      end
      S_VAR:  verdict_q <= VerdictPoor;
      S_MY:   px_q <= round_sat(prod_q);
      S_SUB:  py_q <= round_sat(prod_q);
      S_DIVW: if (div_st.done) avg_q[comp_q] <= PosW'(quo_signed);
      S_SQ1:  acc_q <= 42'(prod_q);
      S_SQ2:  acc_q <= acc_q + 42'(prod_q);
      S_SQ3:  acc_q <= acc_q + 42'(prod_q);
      S_CMP: begin
        if (last_known_q && !far && (ProdW'(acc_q) < prod_q)) verdict_q <= VerdictClose;
        else verdict_q <= VerdictEmit;
      end
      default: ;
    endcase
    if (state_q == S_MY) drop_q <= (fill_q >= len);
    if (state_q == S_OUT && out_free) begin
      out_verdict_q <= verdict_q;
      if (verdict_q == VerdictEmit) begin
        out_x_q <= avg_q[0];
        out_y_q <= avg_q[1];
        out_z_q <= avg_q[2][AltW-1:0];
      end else begin
        out_x_q <= '0;
        out_y_q <= '0;
        out_z_q <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = out_verdict_q;
  assign pos_x_o     = out_x_q;
  assign pos_y_o     = out_y_q;
  assign pos_z_o     = out_z_q;

endmodule

// ===== tb/gps_fix_smoothing_filter_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_fix_smoothing_filter_top_tb
// Self-checking bench for the GPS fix smoothing filter.
// ----------------------------------------------------------------------------
// A queue-fed driver offers fixes with random gaps while a receiver stalls at
// random and once for a long stretch. Each accepted fix runs through an
// in-bench model of the gate, origin, window average and motion test, and
// every result word is compared field by field with the oldest expected word.
// Several register settings are visited, extremes included, between phases.
// ----------------------------------------------------------------------------
module gps_fix_smoothing_filter_top_tb;
  import gfs_pkg::*;

  typedef struct {
    bit                 fv;
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    bit                 ap;
    logic signed [27:0] alt;
    logic [39:0]        var2;
  } fix_t;

  typedef struct {
    logic [2:0]         verdict;
    logic signed [40:0] x;
    logic signed [40:0] y;
    logic signed [28:0] z;
  } smooth_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic fix_valid_i = 1'b0;
  logic signed [30:0] lat_e7_i = '0;
  logic signed [31:0] lon_e7_i = '0;
  logic alt_present_i = 1'b0;
  logic signed [27:0] alt_mm_i = '0;
  logic [39:0] h_variance_mm2_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] verdict_o;
  logic signed [40:0] pos_x_o;
  logic signed [40:0] pos_y_o;
  logic signed [28:0] pos_z_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  gps_fix_smoothing_filter_top dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("gps_fix_smoothing_filter_top_tb NOT OK");
    $finish;
  end

  // model state
  logic [4:0]  win_len;
  logic [23:0] scale;
  logic [19:0] min_move;
  logic [19:0] max_sigma;
  bit          origin_set;
  longint      org_lat, org_lon, org_alt;
  longint      win_pts[MaxWindowDef][3];
  int          win_head, win_fill;
  longint      win_sum[3];
  bit          last_set;
  longint      last_pt[3];

  fix_t    fix_q[$];
  smooth_t smooth_q[$];
  bit      in_taken = 0, out_taken = 0, cfg_taken = 0;
  bit      tx_idle = 1, rx_idle = 1, hold_off = 0, pressure_go = 0;
  int      gap_left = 0, stall_left = 0;
  int      mismatches = 0, words_out = 0;
  int      verdict_cnt[5];
  fix_t    cur;
  int      walk_lat = 100000, walk_lon = 200000, walk_alt = 5000;

  function automatic longint div_round(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint abs_l(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint sat41(longint v);
    longint hi;
    hi = (longint'(1) << 40) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic smooth_t smooth_fix(fix_t f);
    smooth_t r;
    longint  lat, lon, alt, sig2, lim, d0, d1, d2;
    longint  pt[3];
    longint  avg[3];
    int      len, old;
    lat = longint'(f.lat);
    lon = longint'(f.lon);
    alt = longint'(f.alt);
    sig2 = longint'(max_sigma) * longint'(max_sigma);
    r.verdict = VerdictEmit;
    r.x = '0;
    r.y = '0;
    r.z = '0;
    if (!f.fv) begin
      r.verdict = VerdictInval;
    end else if (abs_l(lat) < 10 && abs_l(lon) < 10) begin
      r.verdict = VerdictZero;
    end else if (longint'(f.var2) > sig2) begin
      r.verdict = VerdictPoor;
    end else begin
      if (!origin_set) begin
        org_lat = lat;
        org_lon = lon;
        org_alt = f.ap ? alt : 0;
        origin_set = 1;
      end
      pt[0] = sat41(div_round((lon - org_lon) * longint'(scale), 65536));
      pt[1] = sat41(div_round((lat - org_lat) * longint'(scale), 65536));
      pt[2] = f.ap ? alt - org_alt : 0;
      len = int'(win_len);
      if (len < 1) len = 1;
      if (len > MaxWindowDef) len = MaxWindowDef;
      if (win_fill + 1 > len) begin
        old = (win_head + MaxWindowDef - win_fill) % MaxWindowDef;
        for (int i = 0; i < 3; i++) win_sum[i] -= win_pts[old][i];
        win_fill--;
      end
      for (int i = 0; i < 3; i++) begin
        win_pts[win_head][i] = pt[i];
        win_sum[i] += pt[i];
      end
      win_head = (win_head + 1) % MaxWindowDef;
      win_fill++;
      for (int i = 0; i < 3; i++) avg[i] = div_round(win_sum[i], win_fill);
      if (last_set) begin
        d0 = abs_l(avg[0] - last_pt[0]);
        d1 = abs_l(avg[1] - last_pt[1]);
        d2 = abs_l(avg[2] - last_pt[2]);
        lim = longint'(1) << 20;
        if (d0 < lim && d1 < lim && d2 < lim &&
            d0 * d0 + d1 * d1 + d2 * d2 < longint'(min_move) * longint'(min_move))
          r.verdict = VerdictClose;
      end
      if (r.verdict == VerdictEmit) begin
        for (int i = 0; i < 3; i++) last_pt[i] = avg[i];
        last_set = 1;
        r.x = 41'(avg[0]);
        r.y = 41'(avg[1]);
        r.z = 29'(avg[2]);
      end
    end
    return r;
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (fix_q.size() > 0) begin
        cur = fix_q[0];
        fix_q.delete(0);
        fix_valid_i <= cur.fv;
        lat_e7_i <= cur.lat;
        lon_e7_i <= cur.lon;
        alt_present_i <= cur.ap;
        alt_mm_i <= cur.alt;
        h_variance_mm2_i <= cur.var2;
        in_valid_i <= 1'b1;
        gap_left <= tx_idle ? $urandom_range(0, 9) : 0;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(negedge clk_i) begin
    if (out_taken) stall_left = rx_idle ? $urandom_range(0, 9) : 0;
    if (hold_off) begin
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    wait (pressure_go);
    @(posedge clk_i);
    hold_off = 1;
    repeat (600) @(posedge clk_i);
    hold_off = 0;
  end

  // monitor
  always @(posedge clk_i) begin
    fix_t    f;
    smooth_t e;
    in_taken <= in_valid_i && !in_stall_o;
    out_taken <= out_valid_o && !out_stall_i;
    cfg_taken <= cfg_valid_i && cfg_ready_o;
    if (in_valid_i && !in_stall_o) begin
      f.fv = fix_valid_i;
      f.lat = lat_e7_i;
      f.lon = lon_e7_i;
      f.ap = alt_present_i;
      f.alt = alt_mm_i;
      f.var2 = h_variance_mm2_i;
      smooth_q.insert(smooth_q.size(), smooth_fix(f));
    end
    if (out_valid_o && !out_stall_i) begin
      words_out++;
      if (smooth_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word, verdict %0d", verdict_o);
      end else begin
        e = smooth_q[0];
        smooth_q.delete(0);
        if (e.verdict <= VerdictClose) verdict_cnt[e.verdict]++;
        if (verdict_o !== e.verdict || pos_x_o !== e.x || pos_y_o !== e.y ||
            pos_z_o !== e.z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp v%0d (%0d,%0d,%0d) got v%0d (%0d,%0d,%0d)",
                     e.verdict, e.x, e.y, e.z, verdict_o, pos_x_o, pos_y_o, pos_z_o);
        end
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegWindowLen: win_len = val[4:0];
      RegScale:     scale = val[23:0];
      RegMinMove:   min_move = val[19:0];
      RegMaxSigma:  max_sigma = val[19:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    while (fix_q.size() > 0 || smooth_q.size() > 0 || in_valid_i) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic setup(int len, int scl, int mv, int sg, bit ti, bit ri);
    write_reg(RegWindowLen, CfgDataW'(len));
    write_reg(RegScale, CfgDataW'(scl));
    write_reg(RegMinMove, CfgDataW'(mv));
    write_reg(RegMaxSigma, CfgDataW'(sg));
    tx_idle = ti;
    rx_idle = ri;
  endtask

  task automatic add_fix(bit fv, longint lat, longint lon, bit ap, longint alt, longint v);
    fix_t f;
    f.fv = fv;
    f.lat = 31'(lat);
    f.lon = 32'(lon);
    f.ap = ap;
    f.alt = 28'(alt);
    f.var2 = 40'(v);
    fix_q.insert(fix_q.size(), f);
  endtask

  function automatic int step_of();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 3;
      2: return 40;
      3: return 2000;
      default: return 200000;
    endcase
  endfunction

  task automatic add_random();
    int     r, s;
    longint sig2, v;
    sig2 = longint'(max_sigma) * longint'(max_sigma);
    r = $urandom_range(0, 99);
    v = {$urandom, $urandom} & 40'hff_ffff_ffff;
    if (r < 8) begin
      add_fix(0, $signed(31'($urandom)), $signed($urandom), $urandom_range(0, 1),
              $signed(28'($urandom)), v);
    end else if (r < 12) begin
      add_fix(1, $signed($urandom_range(0, 18)) - 9, $signed($urandom_range(0, 18)) - 9,
              $urandom_range(0, 1), $signed(28'($urandom)), 0);
    end else if (r < 17 && sig2 < 40'hff_ffff_ffff) begin
      add_fix(1, walk_lat, walk_lon, 1, walk_alt,
              sig2 + 1 + (v % (40'hff_ffff_ffff - sig2)));
    end else if (r < 22) begin
      add_fix(1, $signed(31'($urandom)), $signed($urandom), $urandom_range(0, 1),
              $signed(28'($urandom)), v % (sig2 + 1));
    end else begin
      s = step_of();
      walk_lat += $signed($urandom_range(0, 2 * s)) - s;
      walk_lon += $signed($urandom_range(0, 2 * s)) - s;
      walk_alt += $signed($urandom_range(0, 2 * s)) - s;
      if (walk_lat > 900000000 || walk_lat < -900000000) walk_lat = 100000;
      if (walk_lon > 1800000000 || walk_lon < -1800000000) walk_lon = 200000;
      if (walk_alt > 100000000 || walk_alt < -1000000) walk_alt = 5000;
      add_fix(1, walk_lat, walk_lon, $urandom_range(0, 9) != 0, walk_alt, v % (sig2 + 1));
    end
  endtask

  task automatic run_phase(int len, int scl, int mv, int sg, bit ti, bit ri, int n);
    setup(len, scl, mv, sg, ti, ri);
    for (int i = 0; i < n; i++) add_random();
  endtask

  initial begin
    win_len = 5;
    scale = 655360;
    min_move = 1000;
    max_sigma = 5000;
    origin_set = 0;
    org_lat = 0;
    org_lon = 0;
    org_alt = 0;
    win_head = 0;
    win_fill = 0;
    last_set = 0;
    for (int i = 0; i < 3; i++) begin
      win_sum[i] = 0;
      last_pt[i] = 0;
    end
    for (int i = 0; i < 5; i++) verdict_cnt[i] = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (4) @(posedge clk_i);

    add_fix(0, 100000, 200000, 1, 0, 0);
    add_fix(1, 9, -9, 1, 0, 0);
    add_fix(1, 0, 0, 1, 0, 0);
    add_fix(1, -9, 9, 1, 0, 0);
    add_fix(1, 100000, 200000, 1, 0, 25000001);
    add_fix(1, 100000, 200000, 1, 0, 40'hff_ffff_ffff);
    add_fix(1, 100000, 200000, 0, 777, 25000000);
    add_fix(1, 100000, 200000, 1, 0, 0);
    add_fix(1, 101000, 200000, 1, 100000000, 0);
    add_fix(1, 9, 10, 1, 0, 0);
    add_fix(1, -10, 0, 0, 0, 0);
    add_fix(1, -900000000, -1800000000, 1, -1000000, 0);
    add_fix(1, 900000000, 1800000000, 1, 100000000, 0);
    settle();
    setup(16, 24'hff_ffff, 20'hf_ffff, 20'hf_ffff, 1, 1);
    add_fix(1, 31'sh3fff_ffff, 32'sh7fff_ffff, 1, 28'sh7ff_ffff, 0);
    add_fix(1, -31'sh4000_0000, -32'sh8000_0000, 1, -28'sh800_0000, 0);
    add_fix(1, 31'sh3fff_ffff, -32'sh8000_0000, 0, 0, 40'hff_ffff_ffff);
    add_fix(1, -31'sh4000_0000, 32'sh7fff_ffff, 1, 28'sh7ff_ffff, 12345);
    add_fix(1, 100000, 200000, 1, 0, 0);
    settle();

    run_phase(5, 655360, 1000, 5000, 1, 1, 300);
    repeat (50) @(posedge clk_i);
    pressure_go = 1;
    settle();
    run_phase(1, 24'hff_ffff, 0, 20'hf_ffff, 1, 1, 250);
    settle();
    run_phase(16, 65536, 20'hf_ffff, 1000, 0, 0, 250);
    settle();
    run_phase(0, 0, 500, 0, 1, 0, 200);
    settle();
    run_phase(31, 1000000, 2000, 20000, 0, 1, 250);
    settle();
    run_phase(8, 655360, 300, 5000, 1, 1, 250);
    settle();
    run_phase(3, 200000, 100, 20'hf_ffff, 1, 1, 200);
    settle();

    $display("covered %0d result words: %0d emitted, %0d invalid, %0d zero, %0d poor,",
             words_out, verdict_cnt[0], verdict_cnt[1], verdict_cnt[2], verdict_cnt[3]);
    $display("%0d too close, across eight register settings; %0d mismatches",
             verdict_cnt[4], mismatches);
    if (mismatches == 0 && smooth_q.size() == 0) begin
      $display("gps_fix_smoothing_filter_top_tb OK");
    end else begin
      $display("gps_fix_smoothing_filter_top_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/gfs_pkg.sv
design/gfs_div.sv
design/gfs_win.sv
design/gps_fix_smoothing_filter_top.sv
tb/gps_fix_smoothing_filter_top_tb.sv
